@@ rtl/cccc_pkg.sv @@
// ----------------------------------------------------------------------------
// Cycle counter calibration package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package cccc_pkg;
  localparam int unsigned BASE_CLOCK_HZ = 1193182;
  localparam int unsigned MAX_ATTEMPTS  = 12;
  localparam logic [63:0] FREQ_MIN_HZ = 64'd50000000;
  localparam logic [63:0] FREQ_MAX_HZ = 64'd100000000000;
  localparam logic [36:0] FALLBACK_HZ = 37'd2000000000;
  localparam logic [63:0] NS_PER_S    = 64'd1000000000;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_FALLBACK = 2'd2,
    ST_CONVERT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_EST,
    OP_DIV_Q,
    OP_DIV_R,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;
endpackage
`default_nettype wire

@@ rtl/cccc_divider.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
`default_nettype none
module cccc_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient,
  output logic [63:0]      remainder
);
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  always_comb begin
    shifted  = {rem_r[63:0], q_r[63]};
    trial    = shifted - {1'b0, d_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[63:0];
endmodule
`default_nettype wire

@@ rtl/cccc_datapath.sv @@
// ----------------------------------------------------------------------------
// Calibration datapath
// Operand registers, multipliers, shared divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module cccc_datapath #(
  parameter int unsigned BASE_CLOCK_HZ = cccc_pkg::BASE_CLOCK_HZ,
  parameter int unsigned MAX_ATTEMPTS  = cccc_pkg::MAX_ATTEMPTS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [15:0]         reload_count,
  input  wire logic                in_opcode,
  input  wire logic [15:0]         in_start,
  input  wire logic [15:0]         in_end,
  input  wire logic [63:0]         in_delta,
  input  wire logic [63:0]         in_ts,
  input  wire cccc_pkg::dp_cmd_t   cmd,
  output cccc_pkg::dp_status_t     stat,
  output logic [1:0]               res_status,
  output logic [63:0]              res_freq,
  output logic [63:0]              res_ns
);
  logic        opc_r;
  logic [63:0] num_r, den_r, ts_r, qs_r;
  logic [36:0] freq_r, freq_nxt;
  logic [3:0]  fail_r, fail_nxt, fail_inc;
  logic [1:0]  st_r, st_nxt;
  logic [63:0] rf_r, rf_nxt, rn_r, rn_nxt;
  logic        zero_r;
  logic [31:0] count;
  logic        div_start;
  logic [63:0] div_a, div_b, quo, rem;
  logic        div_done;
  logic        in_range;
  logic [63:0] rem_ns;

  // The product modulo 2^64 of a 64-bit value and a 32-bit constant, built
  // from two 32 by 32 bit multiplies.
  function automatic logic [63:0] mul_wrap(input logic [63:0] a, input logic [31:0] c);
    logic [63:0] lo;
    logic [31:0] hi;
    lo = {32'd0, a[31:0]} * {32'd0, c};
    hi = a[63:32] * c;
    return lo + {hi, 32'd0};
  endfunction

  always_comb begin
    if (in_end <= in_start) count = {16'd0, in_start - in_end};
    else count = {16'd0, in_start} + ({16'd0, reload_count} - {16'd0, in_end});
  end

  assign rem_ns = mul_wrap(rem, 32'(cccc_pkg::NS_PER_S));

  always_comb begin
    div_start = 1'b0;
    div_a = num_r;
    div_b = den_r;
    unique case (cmd.op)
      cccc_pkg::OP_DIV_EST: begin
        div_start = 1'b1;
      end
      cccc_pkg::OP_DIV_Q: begin
        div_start = 1'b1;
        div_a = ts_r;
        div_b = {27'd0, freq_r};
      end
      cccc_pkg::OP_DIV_R: begin
        div_start = 1'b1;
        div_a = rem_ns;
        div_b = {27'd0, freq_r};
      end
      default: begin
      end
    endcase
  end

  cccc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(quo), .remainder(rem)
  );

  assign in_range = (quo >= cccc_pkg::FREQ_MIN_HZ) && (quo <= cccc_pkg::FREQ_MAX_HZ);
  assign fail_inc = fail_r + 4'd1;

  always_comb begin
    freq_nxt = freq_r;
    fail_nxt = fail_r;
    st_nxt   = st_r;
    rf_nxt   = rf_r;
    rn_nxt   = rn_r;
    if (cmd.op == cccc_pkg::OP_FINISH) begin
      if (opc_r) begin
        st_nxt = cccc_pkg::ST_CONVERT;
        rf_nxt = {27'd0, freq_r};
        rn_nxt = (freq_r == '0) ? 64'd0 : qs_r + quo;
      end else begin
        rf_nxt = zero_r ? 64'd0 : quo;
        rn_nxt = 64'd0;
        if (!zero_r && in_range) begin
          freq_nxt = quo[36:0];
          fail_nxt = '0;
          st_nxt   = cccc_pkg::ST_ACCEPTED;
        end else if (fail_inc >= 4'(MAX_ATTEMPTS)) begin
          freq_nxt = cccc_pkg::FALLBACK_HZ;
          fail_nxt = '0;
          st_nxt   = cccc_pkg::ST_FALLBACK;
        end else begin
          fail_nxt = fail_inc;
          st_nxt   = cccc_pkg::ST_REJECTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == cccc_pkg::OP_LOAD) begin
      opc_r  <= in_opcode;
      num_r  <= mul_wrap(in_delta, BASE_CLOCK_HZ);
      den_r  <= {31'd0, count, 1'b0};
      ts_r   <= in_ts;
      zero_r <= (count == 32'd0) || (in_delta == 64'd0);
    end
    if (cmd.op == cccc_pkg::OP_DIV_R) begin
      qs_r <= mul_wrap(quo, 32'(cccc_pkg::NS_PER_S));
    end
    st_r <= st_nxt;
    rf_r <= rf_nxt;
    rn_r <= rn_nxt;
    if (!rst_n) begin
      freq_r <= '0;
      fail_r <= '0;
    end else begin
      freq_r <= freq_nxt;
      fail_r <= fail_nxt;
    end
  end

  assign stat.div_done = div_done;
  assign res_status    = st_r;
  assign res_freq      = rf_r;
  assign res_ns        = rn_r;
endmodule
`default_nettype wire

@@ rtl/cccc_control.sv @@
// ----------------------------------------------------------------------------
// Calibration controller
// Sequences load, divisions and result hand-off for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module cccc_control (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_opcode,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output cccc_pkg::dp_cmd_t         cmd,
  input  wire cccc_pkg::dp_status_t stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WAIT_EST, S_WAIT_Q, S_WAIT_R, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic   conv_r;
  logic   out_valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.op = cccc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE:     if (in_tvalid && in_tready) cmd.op = cccc_pkg::OP_LOAD;
      S_START:    cmd.op = conv_r ? cccc_pkg::OP_DIV_Q : cccc_pkg::OP_DIV_EST;
      S_WAIT_Q:   if (stat.div_done) cmd.op = cccc_pkg::OP_DIV_R;
      S_FIN:      if (!out_valid_r || out_tready) cmd.op = cccc_pkg::OP_FINISH;
      default:    cmd.op = cccc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            conv_r  <= in_opcode;
            state_r <= S_START;
          end
        end
        S_START:    state_r <= conv_r ? S_WAIT_Q : S_WAIT_EST;
        S_WAIT_EST: if (stat.div_done) state_r <= S_FIN;
        S_WAIT_Q:   if (stat.div_done) state_r <= S_WAIT_R;
        S_WAIT_R:   if (stat.div_done) state_r <= S_FIN;
        S_FIN:      if (!out_valid_r || out_tready) state_r <= S_OUT;
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default:    state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/cycle_counter_calibrate_and_convert_core.sv @@
// ----------------------------------------------------------------------------
// Cycle counter calibrate and convert core
// Calibrates a cycle counter against a reference counter, converts to ns.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata fields (low to high)                 | tuser
// in_     | input     | start_count, end_count, cycle_delta, ts    | opcode
// out_    | output    | cal_freq, nanoseconds                      | status
// cfg_    | input     | reload_count                               | none
// A calibration request runs one division and a conversion request two, on
// the serial divider, which yields one quotient bit per cycle; the result is
// registered after the last division, and the next request can be accepted in
// the same cycle as the result becomes valid.
// Reset is synchronous and clears the stored frequency and failure count.
// A result waiting on out_tready holds the following request at its last step.
`default_nettype none
module cycle_counter_calibrate_and_convert_core #(
  parameter int unsigned BASE_CLOCK_HZ = cccc_pkg::BASE_CLOCK_HZ,
  parameter int unsigned MAX_ATTEMPTS  = cccc_pkg::MAX_ATTEMPTS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [159:0] in_tdata,  // start_count, end_count, cycle_delta, timestamp
  input  wire logic         in_tuser,  // opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata, // cal_freq, nanoseconds
  output logic [1:0]        out_tuser  // status
);
  logic [15:0]          reload_r;
  cccc_pkg::dp_cmd_t    cmd;
  cccc_pkg::dp_status_t stat;
  logic [63:0]          rf, rn;

  always_ff @(posedge clk) begin
    if (!rst_n) reload_r <= 16'hFFFF;
    else if (cfg_we) reload_r <= cfg_wdata;
  end

  cccc_control u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_opcode(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .stat(stat)
  );

  cccc_datapath #(.BASE_CLOCK_HZ(BASE_CLOCK_HZ), .MAX_ATTEMPTS(MAX_ATTEMPTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .reload_count(reload_r), .in_opcode(in_tuser),
    .in_start(in_tdata[15:0]), .in_end(in_tdata[31:16]), .in_delta(in_tdata[95:32]),
    .in_ts(in_tdata[159:96]), .cmd(cmd), .stat(stat), .res_status(out_tuser),
    .res_freq(rf), .res_ns(rn)
  );

  assign out_tdata = {rn, rf};
endmodule
`default_nettype wire
